FILE: design/sgf_tok_pkg.sv
// ----------------------------------------------------------------------------
// sgf_tok_pkg
// Shared types and constants for the game-record property tokenizer.
// ----------------------------------------------------------------------------
package sgf_tok_pkg;

   localparam int LINE_COUNT_WIDTH_DEF = 16;

   localparam logic [7:0] CH_LBRACK = 8'h5b;  // '['
   localparam logic [7:0] CH_RBRACK = 8'h5d;  // ']'
   localparam logic [7:0] CH_SEMI   = 8'h3b;  // ';'
   localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
   localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
   localparam logic [7:0] CH_BSLASH = 8'h5c;  // '\'
   localparam logic [7:0] CH_NL     = 8'h0a;

   localparam logic [15:0] LINE_OUT_MAX = 16'hffff;

   typedef enum logic [2:0] {
      EV_VALUE_BYTE = 3'd0,
      EV_VALUE_END  = 3'd1,
      EV_PROP_DONE  = 3'd2,
      EV_PUNCT      = 3'd3,
      EV_BAD_TOKEN  = 3'd4
   } event_kind_type;

   typedef enum logic [1:0] {
      PH_NAME  = 2'd0,
      PH_VALUE = 2'd1,
      PH_AFTER = 2'd2
   } lex_phase_type;

   typedef struct packed {
      event_kind_type kind;
      logic [15:0]    tok;
      logic [7:0]     vbyte;
      logic [15:0]    line;
      logic           last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } lex_out_type;

   typedef struct packed {
      logic           hit;
      event_kind_type kind;
      logic [15:0]    tok;
      logic           clr;
      logic           to_value;
      logic [15:0]    code;
      logic [1:0]     len;
   } name_res_type;

endpackage

FILE: design/sgf_tok_lexer.sv
// ----------------------------------------------------------------------------
// sgf_tok_lexer
// Lexer state and the per-byte decode producing up to two result items.
// ----------------------------------------------------------------------------
module sgf_tok_lexer
   import sgf_tok_pkg::*;
#(
   parameter int LINE_COUNT_WIDTH = LINE_COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  text_byte,
   input  logic        end_of_input,
   output lex_out_type lex_out
);

   lex_phase_type               phase_ff, phase_in;
   logic                        esc_ff, esc_in;
   logic [15:0]                 code_ff, code_in;
   logic [1:0]                  len_ff, len_in;
   logic [LINE_COUNT_WIDTH-1:0] line_ff, line_in;
   logic [31:0]                 line_ext;
   logic [15:0]                 line_sat;
   name_res_type                nr;

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {[8'h09:8'h0d], 8'h20});
   endfunction

   function automatic name_res_type name_lex(input logic [7:0] c, input logic esc,
                                             input logic [15:0] code,
                                             input logic [1:0] len);
      name_res_type r;
      logic         lower;
      logic         punct;
      r        = '0;
      r.kind   = EV_VALUE_BYTE;
      r.code   = code;
      r.len    = len;
      lower    = (c inside {[8'h61:8'h7a]});
      punct    = (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN);
      if (!esc && code == 16'h0 && punct) begin
         r.hit  = 1'b1;
         r.kind = EV_PUNCT;
         r.tok  = {8'h00, c};
         r.clr  = 1'b1;
      end else if (!lower && !is_space(c) && c != CH_LBRACK) begin
         if (len >= 2'd2) begin
            r.hit  = 1'b1;
            r.kind = EV_BAD_TOKEN;
            r.clr  = 1'b1;
         end else begin
            r.code = code | ((len == 2'd0) ? {8'h00, c} : {c, 8'h00});
            r.len  = len + 2'd1;
         end
      end else if (!esc && c == CH_LBRACK) begin
         r.to_value = 1'b1;
      end
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      esc_in   = esc_ff;
      code_in  = code_ff;
      len_in   = len_ff;
      line_in  = line_ff;
      lex_out  = '0;
      nr       = '0;
      lex_out.r0.kind = EV_VALUE_BYTE;
      lex_out.r1.kind = EV_VALUE_BYTE;

      if (end_of_input) begin
         lex_out.count = 2'd1;
         if (phase_ff == PH_AFTER) begin
            lex_out.r0.kind = EV_PROP_DONE;
            lex_out.r0.tok  = code_ff;
         end else begin
            lex_out.r0.kind = EV_BAD_TOKEN;
         end
         phase_in = PH_NAME;
         esc_in   = 1'b0;
         code_in  = '0;
         len_in   = '0;
      end else begin
         if (text_byte == CH_NL && line_ff != '1) begin
            line_in = line_ff + 1'b1;
         end
         esc_in = !esc_ff && (text_byte == CH_BSLASH);
         case (phase_ff)
            PH_VALUE: begin
               lex_out.count = 2'd1;
               if (!esc_ff && text_byte == CH_RBRACK) begin
                  phase_in        = PH_AFTER;
                  lex_out.r0.kind = EV_VALUE_END;
               end else begin
                  lex_out.r0.vbyte = text_byte;
               end
            end
            PH_AFTER: begin
               if (!esc_ff && text_byte == CH_LBRACK) begin
                  phase_in = PH_VALUE;
               end else if (!is_space(text_byte) && text_byte != CH_LBRACK) begin
                  // property ends; this byte starts the next token
                  lex_out.count   = 2'd1;
                  lex_out.r0.kind = EV_PROP_DONE;
                  lex_out.r0.tok  = code_ff;
                  nr       = name_lex(text_byte, 1'b0, 16'h0, 2'd0);
                  phase_in = nr.to_value ? PH_VALUE : PH_NAME;
                  esc_in   = (text_byte == CH_BSLASH) && !nr.clr;
                  code_in  = nr.clr ? 16'h0 : nr.code;
                  len_in   = nr.clr ? 2'd0 : nr.len;
                  if (nr.hit) begin
                     lex_out.count   = 2'd2;
                     lex_out.r1.kind = nr.kind;
                     lex_out.r1.tok  = nr.tok;
                  end
               end
            end
            default: begin
               nr = name_lex(text_byte, esc_ff, code_ff, len_ff);
               if (nr.to_value) begin
                  phase_in = PH_VALUE;
               end
               code_in = nr.code;
               len_in  = nr.len;
               if (nr.clr) begin
                  phase_in = PH_NAME;
                  esc_in   = 1'b0;
                  code_in  = '0;
                  len_in   = '0;
               end
               if (nr.hit) begin
                  lex_out.count   = 2'd1;
                  lex_out.r0.kind = nr.kind;
                  lex_out.r0.tok  = nr.tok;
               end
            end
         endcase
      end

      lex_out.r0.line = line_sat;
      lex_out.r1.line = line_sat;
      lex_out.r0.last = (lex_out.count == 2'd1);
      lex_out.r1.last = 1'b1;
   end

   assign line_ext = 32'(line_in);
   assign line_sat = (line_ext > 32'(LINE_OUT_MAX)) ? LINE_OUT_MAX : line_ext[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NAME;
         esc_ff   <= 1'b0;
         code_ff  <= '0;
         len_ff   <= '0;
         line_ff  <= LINE_COUNT_WIDTH'(1);
      end else if (step) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         code_ff  <= code_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
      end
   end

   a_eoi_clears: assert property (@(posedge clock) disable iff (reset)
      (step && end_of_input) |=> (phase_ff == PH_NAME && !esc_ff && code_ff == 16'h0
                                  && len_ff == 2'd0))
      else $error("token state not cleared after end of input");

   a_line_inc: assert property (@(posedge clock) disable iff (reset)
      (step && !end_of_input && text_byte == CH_NL && line_ff != '1)
         |=> (line_ff == $past(line_ff) + 1'b1))
      else $error("line counter missed a newline");

endmodule

FILE: design/sgf_tok_out.sv
// ----------------------------------------------------------------------------
// sgf_tok_out
// Two-slot result register; the second slot holds the follow-on item of a
// byte that yields two results.
// ----------------------------------------------------------------------------
module sgf_tok_out
   import sgf_tok_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  lex_out_type lex_out,
   output logic        can_take,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // token_code[15:0], value_byte[23:16], line_number[39:24]
   output logic [2:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast
);

   logic       s0_v_ff, s0_v_in, s1_v_ff, s1_v_in;
   result_type s0_ff, s0_in, s1_ff, s1_in;
   logic       pop;

   assign pop      = s0_v_ff && rsp_tready;
   assign can_take = !s1_v_ff && (!s0_v_ff || pop);

   always_comb begin
      s0_v_in = s0_v_ff;
      s1_v_in = s1_v_ff;
      s0_in   = s0_ff;
      s1_in   = s1_ff;
      if (pop) begin
         s0_v_in = 1'b0;
      end
      if (pop && s1_v_ff) begin
         s0_v_in = 1'b1;
         s0_in   = s1_ff;
         s1_v_in = 1'b0;
      end
      if (load && lex_out.count != 2'd0) begin
         s0_v_in = 1'b1;
         s0_in   = lex_out.r0;
         s1_v_in = (lex_out.count == 2'd2);
         s1_in   = lex_out.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= s0_v_in;
         s1_v_ff <= s1_v_in;
      end
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

   assign rsp_tvalid = s0_v_ff;
   assign rsp_tdata  = {s0_ff.line, s0_ff.vbyte, s0_ff.tok};
   assign rsp_tuser  = s0_ff.kind;
   assign rsp_tlast  = s0_ff.last;

   a_slot_order: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff |-> s0_v_ff)
      else $error("second slot valid with first slot empty");

   a_run_tail: assert property (@(posedge clock) disable iff (reset)
      (s0_v_ff && !s0_ff.last) |-> s1_v_ff)
      else $error("non-final item without its follow-on item");

endmodule

FILE: design/sgf_property_tokenizer.sv
// ----------------------------------------------------------------------------
// sgf_property_tokenizer
// Byte-stream lexer for game-record text: punctuation, property names, raw
// value bytes, value/property end and bad-token events with a running line count.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                         tuser        tlast
//  req_     in   text_byte[7:0]                end_of_input -
//  rsp_     out  token,value_byte,line_number  event_kind   last_of_run
//
//  One byte per cycle while rsp_tready is high: input register, decode,
//  result register. A byte that yields two items (property done plus
//  punctuation or error) holds the next byte until the second item drains.
//  Synchronous active-high reset; line count restarts at 1.
//  rsp_tready low stalls the result slots, then the input register, then req_.
module sgf_property_tokenizer
   import sgf_tok_pkg::*;
#(
   parameter int LINE_COUNT_WIDTH = LINE_COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // text_byte
   input  logic        req_tuser,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // token_code[15:0], value_byte[23:16], line_number[39:24]
   output logic [2:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast
);

   logic        in_v_ff, in_v_in;
   logic [7:0]  in_byte_ff;
   logic        in_eoi_ff;
   logic        can_take;
   logic        step;
   lex_out_type lex_out;

   assign step       = in_v_ff && can_take;
   assign req_tready = !in_v_ff || step;
   assign in_v_in    = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tuser;
      end
   end

   sgf_tok_lexer #(
      .LINE_COUNT_WIDTH(LINE_COUNT_WIDTH)
   ) u_lexer (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .text_byte   (in_byte_ff),
      .end_of_input(in_eoi_ff),
      .lex_out     (lex_out)
   );

   sgf_tok_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .lex_out   (lex_out),
      .can_take  (can_take),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule
